// File: rtl/core/gmps_pkg.sv
`default_nettype none

package gmps_pkg;

   // path sums
   localparam int SUM_W = 32;
   typedef logic [SUM_W-1:0] sum_type;
   localparam sum_type SUM_MAX = '1;

   // column count register
   localparam int COL_COUNT_W = 11;
   typedef logic [COL_COUNT_W-1:0] col_count_type;
   localparam col_count_type COL_COUNT_RESET = col_count_type'(1);

   // register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

`default_nettype wire

// File: rtl/core/gmps_if.sv
`default_nettype none

// one grid cell per item
interface gmps_req_if #(
   parameter int COST_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [COST_BITS-1:0] cell_cost;
   logic                 last_cell;

   modport source (output valid, output cell_cost, output last_cell, input ready);
   modport sink   (input valid, input cell_cost, input last_cell, output ready);
endinterface

// one path sum per finished grid
interface gmps_rsp_if;
   logic              valid;
   logic              ready;
   gmps_pkg::sum_type min_path_sum;

   modport source (output valid, output min_path_sum, input ready);
   modport sink   (input valid, input min_path_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/core/grid_min_path_sum_unit.sv
`default_nettype none

// Minimum down-or-right path sum over a cost grid streamed in row-major order,
// one cell per item. Set column_count (register 0, byte address 0) while idle;
// 0 acts as 1 and values above MAX_COLUMNS act as MAX_COLUMNS, and a write
// restarts the grid. A cell with last_cell set ends the grid and yields one
// item holding its best sum, saturated at 2^32-1; the next cell opens a new
// grid. Throughput is one cell per clock, sustained: the row of best sums
// sits in a memory with one read port and one write port, read into a
// register as the cell enters the compare/add stage, with the written value
// forwarded when a cell reads the entry being written in the same cycle
// (single-column grids). A last cell's sum goes through the compute stage
// and then the output register. Only when a result is held by the sink and the next
// last cell waits to complete does the input stall. No clearing pass after reset.
module grid_min_path_sum_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int COST_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   gmps_req_if.sink                    req_chan,
   gmps_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire gmps_pkg::csr_addr_type csr_paddr,
   input  wire gmps_pkg::csr_data_type csr_pwdata,
   output      gmps_pkg::csr_data_type csr_prdata,
   output      logic                   csr_pready
);

   localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int CMP_W  = (CNT_W > gmps_pkg::COL_COUNT_W) ? CNT_W : gmps_pkg::COL_COUNT_W;
   localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLUMNS);
   localparam logic [CMP_W-1:0] ONE_COL_C  = CMP_W'(1);

   // ---------------- register port ----------------
   gmps_pkg::col_count_type col_count_ff, col_count_in;
   logic                    csr_write;

   // single register: the byte offset bits are not decoded
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = gmps_pkg::csr_data_type'(col_count_ff);
   assign col_count_in = csr_write ? csr_pwdata[gmps_pkg::COL_COUNT_W-1:0] : col_count_ff;

   // csr_paddr carries only the byte offset within the one register
   logic csr_addr_unused;
   assign csr_addr_unused = ^csr_paddr;

   // ---------------- front: position tracking and row read ----------------
   logic [CMP_W-1:0]  count_ext, used_cols, pos_ext, next_ext;
   logic [ADDR_W-1:0] col_pos_ff, col_pos_in, rd_col;
   logic              first_row_ff, first_row_in;
   logic              accept, wrap;

   assign count_ext = CMP_W'(col_count_ff);
   assign used_cols = (count_ext == '0) ? ONE_COL_C :
                      (count_ext > MAX_COLS_C) ? MAX_COLS_C : count_ext;
   assign pos_ext   = CMP_W'(col_pos_ff);
   assign rd_col    = (pos_ext >= used_cols) ? '0 : col_pos_ff;
   assign next_ext  = CMP_W'(rd_col) + ONE_COL_C;
   assign wrap      = next_ext >= used_cols;
   assign accept    = req_chan.valid && req_chan.ready;

   always_comb begin
      col_pos_in   = col_pos_ff;
      first_row_in = first_row_ff;
      if (csr_write) begin
         col_pos_in   = '0;
         first_row_in = 1'b1;
      end else if (accept) begin
         if (req_chan.last_cell) begin
            col_pos_in   = '0;
            first_row_in = 1'b1;
         end else if (wrap) begin
            col_pos_in   = '0;
            first_row_in = 1'b0;
         end else begin
            col_pos_in   = next_ext[ADDR_W-1:0];
         end
      end
   end

   // ---------------- compute stage ----------------
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff, s1_first_ff, s1_col0_ff;
   logic [ADDR_W-1:0]    s1_col_ff;
   logic [COST_BITS-1:0] s1_cost_ff;
   logic                 s1_done, s1_adv;

   gmps_pkg::sum_type    left_ff, left_in;
   gmps_pkg::sum_type    mem_rd_ff;
   gmps_pkg::sum_type    fwd_data_ff;
   logic                 fwd_ff;
   gmps_pkg::sum_type    above, base, best;
   logic [gmps_pkg::SUM_W:0] sum_wide;

   gmps_pkg::sum_type    row_mem [MAX_COLUMNS];

   // a last cell may only finish if the output register has room
   assign s1_done = !s1_last_ff || !rsp_chan.valid || rsp_chan.ready;
   assign s1_adv  = s1_valid_ff && s1_done;
   assign req_chan.ready = !s1_valid_ff || s1_done;
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   assign above = fwd_ff ? fwd_data_ff : mem_rd_ff;

   always_comb begin
      if (s1_first_ff) begin
         base = s1_col0_ff ? '0 : left_ff;
      end else if (s1_col0_ff) begin
         base = above;
      end else begin
         base = (above < left_ff) ? above : left_ff;
      end
      sum_wide = {1'b0, base} + (gmps_pkg::SUM_W + 1)'(s1_cost_ff);
      best = sum_wide[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX : sum_wide[gmps_pkg::SUM_W-1:0];
   end

   assign left_in = s1_adv ? best : left_ff;

   // row memory: one write (compute stage), one registered read (front)
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         row_mem[s1_col_ff] <= best;
      end
      if (accept) begin
         mem_rd_ff   <= row_mem[rd_col];
         // same entry written this edge: the read returns the old word
         fwd_ff      <= s1_adv && (s1_col_ff == rd_col);
         fwd_data_ff <= best;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff  <= req_chan.last_cell;
         s1_first_ff <= first_row_ff;
         s1_col0_ff  <= (rd_col == '0);
         s1_col_ff   <= rd_col;
         s1_cost_ff  <= req_chan.cell_cost;
      end
   end

   // ---------------- output register ----------------
   logic              rsp_valid_ff, rsp_valid_in;
   gmps_pkg::sum_type rsp_sum_ff, rsp_sum_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (s1_adv && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = best;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.min_path_sum = rsp_sum_ff;

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= gmps_pkg::COL_COUNT_RESET;
         col_pos_ff   <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         col_pos_ff   <= col_pos_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- assertions ----------------
   // a new result only ever comes from a last cell leaving the compute stage
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result without a finished last cell");

   // a stalled compute stage keeps its cell and blocks new ones
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_done) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_cost_ff)))
      else $error("compute stage lost a stalled cell");

   // forwarding is taken for every cell reading the column just written
   a_fwd_col: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv && (s1_col_ff == rd_col)) |=> fwd_ff)
      else $error("missed forward of row entry");

endmodule

`default_nettype wire

// File: dv/grid_min_path_sum_unit_test.sv
`timescale 1ns / 1ps

module grid_min_path_sum_unit_test;

   localparam int MAX_COLUMNS = 1024;
   localparam int COST_BITS   = 16;

   // register map: column_count is register 0, so byte address 0
   localparam gmps_pkg::csr_addr_type COLUMN_COUNT_ADDR = gmps_pkg::csr_addr_type'(0);

   // how a grid in the random part is closed off
   typedef enum int unsigned {
      GRID_WHOLE,   // last cell flagged at the bottom-right corner
      GRID_CUT,     // last cell flagged somewhere before the corner
      GRID_OPEN     // no last cell at all, left running
   } grid_style_type;

   typedef logic [COST_BITS-1:0] cost_type;

   // ------------------------------------------------------------------
   // Predictor and result store. Tracks the row of best sums as the block
   // should hold it, queues the path sum of each closed grid and checks
   // the block's results against that queue in order.
   // ------------------------------------------------------------------
   class path_sum_board;
      gmps_pkg::sum_type       above_sums [MAX_COLUMNS];
      gmps_pkg::sum_type       left_best;
      int unsigned             next_col;
      bit                      top_row;
      gmps_pkg::col_count_type columns;
      gmps_pkg::sum_type       due_sums [$];
      int unsigned             faults;

      function new();
         columns = gmps_pkg::COL_COUNT_RESET;
         faults  = 0;
         restart();
      endfunction

      function void restart();
         left_best = '0;
         next_col  = 0;
         top_row   = 1'b1;
      endfunction

      // register write: only the low bits are kept, and the grid restarts
      function void set_columns(gmps_pkg::col_count_type setting);
         columns = setting;
         restart();
      endfunction

      // zero acts as one, anything past the buffer acts as the full buffer
      function int unsigned row_width();
         if (columns == '0)
            return 1;
         if (int'(columns) > MAX_COLUMNS)
            return MAX_COLUMNS;
         return int'(columns);
      endfunction

      function gmps_pkg::sum_type clamp_add(gmps_pkg::sum_type a, gmps_pkg::sum_type b);
         logic [gmps_pkg::SUM_W:0] total;
         total = {1'b0, a} + {1'b0, b};
         return total[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX : total[gmps_pkg::SUM_W-1:0];
      endfunction

      function void note_cell(cost_type cost, logic last);
         int unsigned       width_now;
         int unsigned       col;
         gmps_pkg::sum_type best;
         gmps_pkg::sum_type nearest;
         width_now = row_width();
         col       = (next_col >= width_now) ? 0 : next_col;
         if (top_row) begin
            best = (col == 0) ? gmps_pkg::sum_type'(cost) :
                   clamp_add(left_best, gmps_pkg::sum_type'(cost));
         end else begin
            nearest = above_sums[col];
            if (col != 0 && left_best < nearest)
               nearest = left_best;
            best = clamp_add(nearest, gmps_pkg::sum_type'(cost));
         end
         above_sums[col] = best;
         left_best       = best;
         if (last) begin
            due_sums.push_back(best);
            restart();
         end else if (col + 1 >= width_now) begin
            next_col = 0;
            top_row  = 1'b0;
         end else begin
            next_col = col + 1;
         end
      endfunction

      function void check_sum(gmps_pkg::sum_type seen);
         gmps_pkg::sum_type want;
         if (due_sums.size() == 0) begin
            $error("min_path_sum: no item expected, actual %0d", seen);
            faults++;
            return;
         end
         want = due_sums.pop_front();
         if (seen !== want) begin
            $error("min_path_sum: expected %0d, actual %0d", want, seen);
            faults++;
         end
      endfunction

      function int unsigned pending();
         return due_sums.size();
      endfunction

      function void check_drained();
         while (due_sums.size() != 0) begin
            $error("min_path_sum: expected %0d, never arrived", due_sums.pop_front());
            faults++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gmps_req_if #(.COST_BITS(COST_BITS)) req_bus ();
   gmps_rsp_if                          rsp_bus ();

   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   gmps_pkg::csr_addr_type csr_paddr;
   gmps_pkg::csr_data_type csr_pwdata;
   gmps_pkg::csr_data_type csr_prdata;
   logic                   csr_pready;

   grid_min_path_sum_unit #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .COST_BITS   (COST_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   path_sum_board board;

   // idle rates in percent; changed between phases only
   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   // long hold-off of the result side, raised by its own process
   logic        hold_rsp      = 1'b0;
   int unsigned cells_sent    = 0;

   // ------------------------------------------------------------------
   // Result side: random back-pressure, plus the long hold when asked.
   // ready is only ever changed by NBA just after an edge, so the monitor
   // below always sees the value that the handshake used.
   // ------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || hold_rsp)
            rsp_bus.ready <= 1'b0;
         else
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_sum(rsp_bus.min_path_sum);
   end

   // holds the result side off for a counted stretch of cycles
   task automatic hold_results(int unsigned cycles);
      hold_rsp <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Cell side
   // ------------------------------------------------------------------
   // Offers one cell, with random gaps ahead of it; returns once taken.
   // valid stays high from one item into the next when no gap falls.
   task automatic send_cell(cost_type cost, logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cell_cost <= cost;
      req_bus.last_cell <= last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      board.note_cell(cost, last);
      cells_sent++;
   endtask

   // costs lean on the edges: zero, full scale and small values
   function automatic cost_type pick_cost();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return cost_type'($urandom_range(15));
         default: return cost_type'($urandom);
      endcase
   endfunction

   // a run of random cells, the final one flagged last when close is set
   task automatic send_run(int unsigned count, bit close);
      for (int unsigned i = 0; i < count; i++)
         send_cell(pick_cost(), close && (i == count - 1));
   endtask

   task automatic send_list(cost_type costs [$]);
      foreach (costs[i])
         send_cell(costs[i], i == costs.size() - 1);
   endtask

   // wait for the block to go quiet: nothing owed, then spare cycles so that
   // a cell that produces no item can clear the pipe
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register port: setup then access, then read back
   // ------------------------------------------------------------------
   task automatic write_columns(gmps_pkg::col_count_type setting);
      gmps_pkg::csr_data_type data;
      data                           = $urandom;
      data[gmps_pkg::COL_COUNT_W-1:0] = setting;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= COLUMN_COUNT_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      board.set_columns(setting);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== gmps_pkg::csr_data_type'(setting)) begin
         $error("column_count: expected %0d, actual %0d", setting, csr_prdata);
         board.faults++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // mostly narrow grids; now and then zero, the full width or beyond it
   function automatic gmps_pkg::col_count_type pick_columns();
      case ($urandom_range(19))
         0:       return '0;
         1:       return gmps_pkg::col_count_type'(MAX_COLUMNS);
         2:       return gmps_pkg::col_count_type'($urandom_range(MAX_COLUMNS + 1, 2047));
         3, 4, 5: return gmps_pkg::col_count_type'($urandom_range(9, 40));
         default: return gmps_pkg::col_count_type'($urandom_range(1, 8));
      endcase
   endfunction

   // one register setting followed by a few grids in it
   task automatic random_setting();
      int unsigned    width;
      int unsigned    rows;
      int unsigned    total;
      grid_style_type style;
      settle();
      write_columns(pick_columns());
      width = board.row_width();
      repeat ($urandom_range(1, 4)) begin
         // wide rows: short grids that close inside the top row
         if (width > 64) begin
            send_run($urandom_range(1, 24), 1'b1);
            continue;
         end
         rows  = $urandom_range(1, 5);
         total = rows * width;
         case ($urandom_range(19))
            0, 1:    style = GRID_OPEN;
            2, 3, 4: style = GRID_CUT;
            default: style = GRID_WHOLE;
         endcase
         case (style)
            GRID_WHOLE: send_run(total, 1'b1);
            GRID_CUT:   send_run($urandom_range(1, total), 1'b1);
            GRID_OPEN: begin
               // runs on row after row; the next register write restarts it
               send_run($urandom_range(1, total + width), 1'b0);
               break;
            end
            default:    send_run(total, 1'b1);
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Run time limit
   // ------------------------------------------------------------------
   initial begin
      #4ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned quota;
      board = new();

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cell_cost <= '0;
      req_bus.last_cell <= 1'b0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, no idling ---
      // reset width of one column: a two-cell column
      send_list('{16'd7, 16'hFFFF});
      settle();
      // textbook three by three grid
      write_columns(11'd3);
      send_list('{16'd1, 16'd3, 16'd1, 16'd1, 16'd5, 16'd1, 16'd4, 16'd2, 16'd1});
      // grid closed mid row, then a fresh grid that closes at the start of row two
      send_list('{16'hFFFF, 16'd0});
      send_list('{16'd0, 16'hFFFF, 16'h8000, 16'd1});
      settle();
      // zero columns behaves as one
      write_columns(11'd0);
      send_list('{16'd5, 16'd0, 16'd9});
      settle();
      // open grid, then a write part-way through restarts it
      write_columns(11'd2);
      send_run(3, 1'b0);
      settle();
      write_columns(11'd2);
      send_list('{16'd4, 16'd1, 16'd2, 16'd3});
      settle();
      // full buffer width, closed early in the top row
      write_columns(gmps_pkg::col_count_type'(MAX_COLUMNS));
      send_list('{16'd3, 16'd4});

      // --- random part over the three idling schemes ---
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_gap_pct  = 26;
               rsp_stall_pct = 66;
            end
            1: begin
               send_gap_pct  = 66;
               rsp_stall_pct = 26;
            end
            default: begin
               send_gap_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         quota = cells_sent + 250;
         while (cells_sent < quota)
            random_setting();
      end

      // --- result side held off while one-cell grids keep coming, so the
      // block has to stall its input ---
      settle();
      write_columns(11'd1);
      fork
         hold_results(300);
      join_none
      repeat (40)
         send_cell(pick_cost(), 1'b1);

      // --- width past the buffer acts as the full buffer; closes in the top row ---
      settle();
      write_columns(11'd2047);
      send_run(20, 1'b1);

      settle();
      repeat (10) @(posedge clock);
      board.check_drained();
      if (board.faults == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
